// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // width of the live length, char count, fill and index fields (holds 0..15)
  localparam int LEN_W = 4;

  // configuration register indexes (paddr[5:3])
  localparam logic [2:0] REG_PATTERN_CHARS     = 3'd0;
  localparam logic [2:0] REG_PATTERN_LEN       = 3'd1;
  localparam logic [2:0] REG_REPLACEMENT_CHARS = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LEN   = 3'd3;
  localparam logic [2:0] REG_OUT_CAPACITY      = 3'd4;

  localparam logic [15:0] CAPACITY_RESET = 16'hffff;

  typedef struct packed {
    logic [63:0] pattern_chars;
    logic [3:0]  pattern_len;
    logic [63:0] replacement_chars;
    logic [3:0]  replacement_len;
    logic [15:0] out_capacity;
  } sfr_cfg_t;

  // one queue entry: a run of characters, optionally closed by a summary
  typedef struct packed {
    logic [LEN_W-1:0] n_chars;
    logic             summary;
    logic [15:0]      length;
    logic [15:0]      count;
    logic             overflow;
  } sfr_job_t;

endpackage

// ===== design/stream_find_replace.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace on 8-bit characters with capacity truncation.
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+------------------
//   input   | in_char in_has_char in_last                  | in_valid/in_ready
//   result  | out_char out_has_char out_last out_length    | out_valid/out_ready
//           | out_count out_overflow                       |
//   config  | psel penable pwrite paddr pwdata prdata      | pready (always 1)
//
// The front takes one input beat per cycle while the queue has room and
// decides in that cycle every result the beat causes.
// The back delivers one result beat per cycle while out_ready is high: a
// replacement of n characters gives n character beats, and a last beat gives
// up to the larger of PATTERN_MAX and REPLACEMENT_MAX characters plus a
// summary beat; QUEUE_DEPTH entries absorb these bursts.
// Synchronous active-low reset clears control state and loads register
// defaults; a stalled output holds its beat while the front keeps accepting
// until the queue fills.
// ----------------------------------------------------------------------------
module stream_find_replace import sfr_pkg::*; #(
  parameter int PATTERN_MAX     = 8,
  parameter int REPLACEMENT_MAX = 8,
  parameter int LENGTH_BITS     = 16,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_has_char,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_has_char,
  output logic        out_last,
  output logic [15:0] out_length,
  output logic [15:0] out_count,
  output logic        out_overflow
);

  localparam int JOB_MAX = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;
  localparam int Q_WIDTH = JOB_MAX * 8 + $bits(sfr_job_t);

  sfr_cfg_t             cfg;
  logic                 queue_full, push, pop, head_valid;
  logic [JOB_MAX*8-1:0] push_chars, head_chars;
  sfr_job_t             push_meta, head_meta;
  logic [Q_WIDTH-1:0]   head_data;

  sfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_front #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX),
    .LENGTH_BITS     (LENGTH_BITS),
    .JOB_MAX         (JOB_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .in_has_char (in_has_char),
    .in_last     (in_last),
    .queue_full  (queue_full),
    .push        (push),
    .push_chars  (push_chars),
    .push_meta   (push_meta)
  );

  sfr_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_chars, push_meta}),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_chars = head_data[Q_WIDTH-1 -: JOB_MAX*8];
  assign head_meta  = head_data[$bits(sfr_job_t)-1:0];

  sfr_back #(
    .JOB_MAX (JOB_MAX)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_chars   (head_chars),
    .head_meta    (head_meta),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_has_char (out_has_char),
    .out_last     (out_last),
    .out_length   (out_length),
    .out_count    (out_count),
    .out_overflow (out_overflow)
  );

endmodule

// ===== design/sfr_cfg.sv =====
// ----------------------------------------------------------------------------
// sfr_cfg
// APB-style register file holding pattern, replacement and capacity.
// ----------------------------------------------------------------------------
module sfr_cfg import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output sfr_cfg_t    cfg
);

  sfr_cfg_t   cfg_r;
  sfr_cfg_t   cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_CHARS:     cfg_nxt.pattern_chars     = pwdata;
        REG_PATTERN_LEN:       cfg_nxt.pattern_len       = pwdata[3:0];
        REG_REPLACEMENT_CHARS: cfg_nxt.replacement_chars = pwdata;
        REG_REPLACEMENT_LEN:   cfg_nxt.replacement_len   = pwdata[3:0];
        REG_OUT_CAPACITY:      cfg_nxt.out_capacity      = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_CHARS:     prdata = cfg_r.pattern_chars;
      REG_PATTERN_LEN:       prdata = 64'(cfg_r.pattern_len);
      REG_REPLACEMENT_CHARS: prdata = cfg_r.replacement_chars;
      REG_REPLACEMENT_LEN:   prdata = 64'(cfg_r.replacement_len);
      REG_OUT_CAPACITY:      prdata = 64'(cfg_r.out_capacity);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_chars     <= '0;
      cfg_r.pattern_len       <= '0;
      cfg_r.replacement_chars <= '0;
      cfg_r.replacement_len   <= '0;
      cfg_r.out_capacity      <= CAPACITY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Accepts characters, keeps the delay window and counters, and turns each
// item with output into one queue entry listing its characters and summary.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
  parameter int PATTERN_MAX     = 8,
  parameter int REPLACEMENT_MAX = 8,
  parameter int LENGTH_BITS     = 16,
  parameter int JOB_MAX         = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char,
  input  logic               in_has_char,
  input  logic               in_last,
  input  logic               queue_full,
  output logic               push,
  output logic [JOB_MAX*8-1:0] push_chars,
  output sfr_job_t           push_meta
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
  localparam logic [LEN_W-1:0]       PAT_MAX_L = LEN_W'(PATTERN_MAX);
  localparam logic [LEN_W-1:0]       REP_MAX_L = LEN_W'(REPLACEMENT_MAX);

  logic [7:0]             win_r [PATTERN_MAX];
  logic [7:0]             win_nxt [PATTERN_MAX];
  logic [7:0]             ins [PATTERN_MAX];
  logic [7:0]             src [PATTERN_MAX];
  logic [7:0]             pat [PATTERN_MAX];
  logic [LEN_W-1:0]       fill_r, fill_nxt, fill_a;
  logic [LEN_W-1:0]       live_len_r, live_len_nxt, live;
  logic [LENGTH_BITS-1:0] written_r, written_nxt, written_a, written_b;
  logic [LENGTH_BITS-1:0] count_r, count_nxt, count_a;
  logic                   ovf_r, ovf_nxt, ovf_a, ovf_b;
  logic                   active_r, active_nxt;
  logic [LENGTH_BITS-1:0] cap, room_a, room_b;
  logic [LEN_W-1:0]       rl, cs, n_a, n_b;
  logic                   accept, take, match, use_rep;

  assign in_ready = !queue_full;

  always_comb begin
    accept = in_valid && in_ready;
    take   = accept && (in_has_char || in_last);
    live   = active_r ? live_len_r :
             ((cfg.pattern_len > PAT_MAX_L) ? PAT_MAX_L : cfg.pattern_len);
    rl     = (cfg.replacement_len > REP_MAX_L) ? REP_MAX_L : cfg.replacement_len;
    cap    = (32'(cfg.out_capacity) > 32'(LEN_MAX)) ? LEN_MAX :
             LENGTH_BITS'(cfg.out_capacity);

    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat[i] = cfg.pattern_chars[8*i +: 8];
      ins[i] = (fill_r == LEN_W'(i)) ? in_char : win_r[i];
    end
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((LEN_W'(i) < live) && (ins[i] != pat[i])) match = 1'b0;
    end

    room_a = (cap > written_r) ? cap - written_r : '0;
    cs     = (room_a < LENGTH_BITS'(rl)) ? room_a[LEN_W-1:0] : rl;

    // character step
    src       = win_r;
    win_nxt   = win_r;
    fill_a    = fill_r;
    written_a = written_r;
    count_a   = count_r;
    ovf_a     = ovf_r;
    n_a       = '0;
    use_rep   = 1'b0;
    if (in_has_char && !ovf_r) begin
      if (live == '0) begin
        src[0]  = in_char;
        win_nxt = src;
        fill_a  = '0;
        if (written_r < cap) begin
          n_a       = LEN_W'(1);
          written_a = written_r + 1'b1;
        end else begin
          ovf_a     = 1'b1;
          written_a = cap;
        end
      end else if (fill_r < live) begin
        src     = ins;
        win_nxt = ins;
        fill_a  = fill_r + 1'b1;
        if (fill_a == live) begin
          if (match) begin
            use_rep = 1'b1;
            n_a     = cs;
            fill_a  = '0;
            if ((rl == '0 || cs != '0) && count_r != LEN_MAX) count_a = count_r + 1'b1;
            if (cs >= rl) begin
              written_a = written_r + LENGTH_BITS'(rl);
            end else begin
              ovf_a     = 1'b1;
              written_a = cap;
            end
          end else if (written_r < cap) begin
            // emit the oldest character and shift the window down
            n_a       = LEN_W'(1);
            written_a = written_r + 1'b1;
            fill_a    = fill_r;
            for (int i = 0; i < PATTERN_MAX - 1; i++) win_nxt[i] = ins[i+1];
          end else begin
            ovf_a     = 1'b1;
            written_a = cap;
            fill_a    = '0;
          end
        end
      end
    end

    // flush step at end of string
    room_b    = (cap > written_a) ? cap - written_a : '0;
    n_b       = '0;
    written_b = written_a;
    ovf_b     = ovf_a;
    if (in_last && fill_a != '0 && !ovf_a) begin
      if (room_b >= LENGTH_BITS'(fill_a)) begin
        n_b       = fill_a;
        written_b = written_a + LENGTH_BITS'(fill_a);
      end else begin
        n_b       = room_b[LEN_W-1:0];
        ovf_b     = 1'b1;
        written_b = cap;
      end
    end

    // emitted characters are the pre-shift window or the replacement text
    push_chars = '0;
    if (use_rep) begin
      for (int i = 0; i < REPLACEMENT_MAX; i++)
        push_chars[8*i +: 8] = cfg.replacement_chars[8*i +: 8];
    end else begin
      for (int i = 0; i < PATTERN_MAX; i++) push_chars[8*i +: 8] = src[i];
    end
    push_meta.n_chars  = n_a + n_b;
    push_meta.summary  = in_last;
    push_meta.length   = in_last ? 16'(written_b) : '0;
    push_meta.count    = in_last ? 16'(count_a) : '0;
    push_meta.overflow = in_last && ovf_b;
    push = take && (push_meta.n_chars != '0 || in_last);

    fill_nxt     = fill_r;
    written_nxt  = written_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    active_nxt   = active_r;
    live_len_nxt = live_len_r;
    if (take) begin
      if (in_last) begin
        fill_nxt    = '0;
        written_nxt = '0;
        count_nxt   = '0;
        ovf_nxt     = 1'b0;
        active_nxt  = 1'b0;
      end else begin
        fill_nxt     = fill_a;
        written_nxt  = written_a;
        count_nxt    = count_a;
        ovf_nxt      = ovf_a;
        active_nxt   = 1'b1;
        live_len_nxt = live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      written_r  <= '0;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      active_r   <= 1'b0;
      live_len_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      written_r  <= written_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      active_r   <= active_nxt;
      live_len_r <= live_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) win_r <= win_nxt;
  end

endmodule

// ===== design/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Short register FIFO between front and back, head visible without a read.
// ----------------------------------------------------------------------------
module sfr_queue import sfr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== design/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Walks the head queue entry one result per beat into the output register.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; #(
  parameter int JOB_MAX = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  logic [JOB_MAX*8-1:0] head_chars,
  input  sfr_job_t             head_meta,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 out_has_char,
  output logic                 out_last,
  output logic [15:0]          out_length,
  output logic [15:0]          out_count,
  output logic                 out_overflow
);

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       char_r, sel;
  logic             has_r, last_r, ovf_r;
  logic [15:0]      length_r, count_r;
  logic             load, is_char, done;

  always_comb begin
    load    = head_valid && (!out_valid_r || out_ready);
    is_char = idx_r < head_meta.n_chars;
    sel     = '0;
    for (int i = 0; i < JOB_MAX; i++) begin
      if (idx_r == LEN_W'(i)) sel = head_chars[8*i +: 8];
    end
    done = is_char ? ((idx_r + 1'b1 == head_meta.n_chars) && !head_meta.summary) : 1'b1;
    pop  = load && done;
    idx_nxt = idx_r;
    if (load) idx_nxt = done ? '0 : idx_r + 1'b1;
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // character beats carry zero summary fields; the summary beat has no char
  always_ff @(posedge clk) begin
    if (load) begin
      char_r   <= is_char ? sel : 8'd0;
      has_r    <= is_char;
      last_r   <= !is_char;
      length_r <= is_char ? 16'd0 : head_meta.length;
      count_r  <= is_char ? 16'd0 : head_meta.count;
      ovf_r    <= !is_char && head_meta.overflow;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = char_r;
  assign out_has_char = has_r;
  assign out_last     = last_r;
  assign out_length   = length_r;
  assign out_count    = count_r;
  assign out_overflow = ovf_r;

endmodule

// ===== test/tb_stream_find_replace.sv =====
// ----------------------------------------------------------------------------
// tb_stream_find_replace
// Self-checking bench for the streaming find-and-replace block. A scoreboard
// class predicts every output beat from the accepted input beats and the
// register settings. Directed strings hit the corner cases, then random
// strings are driven under three idle mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb_stream_find_replace;
  import sfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX    = 8;
  localparam int TEXT_MAX      = 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int QUIET_LIMIT   = 5000;

  typedef struct {
    bit [7:0]  ch;
    bit        has;
    bit        last;
    bit [15:0] length;
    bit [15:0] count;
    bit        ovf;
  } text_beat_t;

  class text_scoreboard;
    bit [63:0]   pat_chars;
    bit [3:0]    pat_len;
    bit [63:0]   rep_chars;
    bit [3:0]    rep_len;
    bit [15:0]   capacity = CAPACITY_RESET;
    bit [7:0]    win[WINDOW_MAX];
    int          fill;
    int          live_len;
    int unsigned written;
    int unsigned replaced;
    bit          ovf_flag;
    bit          active;
    text_beat_t  expected_text[$];
    int          failures;

    function void set_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_CHARS:     pat_chars = value;
        REG_PATTERN_LEN:       pat_len = value[3:0];
        REG_REPLACEMENT_CHARS: rep_chars = value;
        REG_REPLACEMENT_LEN:   rep_len = value[3:0];
        REG_OUT_CAPACITY:      capacity = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    function void push_beat(bit [7:0] ch, bit has, bit last, bit [15:0] length,
                            bit [15:0] count, bit ovf);
      text_beat_t b;
      b.ch = ch;
      b.has = has;
      b.last = last;
      b.length = length;
      b.count = count;
      b.ovf = ovf;
      expected_text.push_back(b);
    endfunction

    function void mark_overflow();
      ovf_flag = 1'b1;
      written = capacity;
      fill = 0;
    endfunction

    function void emit_front();
      if (fill == 0) return;
      if (written < capacity) begin
        push_beat(win[0], 1'b1, 1'b0, 16'd0, 16'd0, 1'b0);
        written++;
        for (int i = 1; i < fill; i++) win[i-1] = win[i];
        fill--;
      end else begin
        mark_overflow();
      end
    endfunction

    function bit window_is_match();
      for (int i = 0; i < live_len; i++)
        if (win[i] != pat_chars[8*i +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void substitute();
      int rl;
      int room;
      int take;
      rl = (rep_len > TEXT_MAX) ? TEXT_MAX : rep_len;
      room = (capacity > written) ? capacity - written : 0;
      take = (room < rl) ? room : rl;
      for (int i = 0; i < take; i++)
        push_beat(rep_chars[8*i +: 8], 1'b1, 1'b0, 16'd0, 16'd0, 1'b0);
      // an empty replacement always counts below saturation; a cut one only if a char got out
      if ((rl == 0 || take > 0) && replaced < 16'hffff) replaced++;
      if (take >= rl) begin
        written += rl;
        fill = 0;
      end else begin
        mark_overflow();
      end
    endfunction

    function void accept_source(logic [7:0] ch, logic has, logic last);
      if (!has && !last) return;
      if (!active) begin
        live_len = (pat_len > WINDOW_MAX) ? WINDOW_MAX : pat_len;
        active = 1'b1;
      end
      if (has && !ovf_flag) begin
        if (live_len == 0) begin
          win[0] = ch;
          fill = 1;
          emit_front();
        end else if (fill < live_len) begin
          win[fill] = ch;
          fill++;
          if (fill == live_len) begin
            if (window_is_match()) substitute();
            else emit_front();
          end
        end
      end
      if (last) begin
        while (fill > 0 && !ovf_flag) emit_front();
        push_beat(8'd0, 1'b0, 1'b1, written[15:0], replaced[15:0], ovf_flag);
        fill = 0;
        written = 0;
        replaced = 0;
        ovf_flag = 1'b0;
        active = 1'b0;
      end
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_output(logic [7:0] ch, logic has, logic last,
                               logic [15:0] length, logic [15:0] count, logic ovf);
      text_beat_t want;
      if (expected_text.size() == 0) begin
        report($sformatf("unexpected beat: ch=%h has=%b last=%b len=%0d cnt=%0d ovf=%b",
                         ch, has, last, length, count, ovf));
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch || has !== want.has || last !== want.last ||
          length !== want.length || count !== want.count || ovf !== want.ovf)
        report($sformatf({"beat mismatch: expected ch=%h has=%b last=%b len=%0d cnt=%0d",
                          " ovf=%b, got ch=%h has=%b last=%b len=%0d cnt=%0d ovf=%b"},
                         want.ch, want.has, want.last, want.length, want.count, want.ovf,
                         ch, has, last, length, count, ovf));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char;
  logic        in_has_char;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic        out_has_char;
  logic        out_last;
  logic [15:0] out_length;
  logic [15:0] out_count;
  logic        out_overflow;

  text_scoreboard sb;
  int tx_idle_pct = 23;
  int rx_idle_pct = 60;
  int rx_hold_req = 0;
  int quiet_cycles = 0;

  stream_find_replace u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_has_char  (in_has_char),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_has_char (out_has_char),
    .out_last     (out_last),
    .out_length   (out_length),
    .out_count    (out_count),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // note the input beat before checking the output beat of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.accept_source(in_char, in_has_char, in_last);
      if (out_valid && out_ready)
        sb.check_output(out_char, out_has_char, out_last, out_length, out_count,
                        out_overflow);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(bit [63:0] pc, bit [3:0] pl, bit [63:0] rc, bit [3:0] rl,
                           bit [15:0] cap);
    write_reg(REG_PATTERN_CHARS, pc);
    write_reg(REG_PATTERN_LEN, 64'(pl));
    write_reg(REG_REPLACEMENT_CHARS, rc);
    write_reg(REG_REPLACEMENT_LEN, 64'(rl));
    write_reg(REG_OUT_CAPACITY, 64'(cap));
  endtask

  task automatic send_beat(bit [7:0] ch, bit has, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char <= ch;
    in_has_char <= has;
    in_last <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // drop valid, wait out every expected beat, then let a flush finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(int n_items, int hold);
    bit [63:0] pc;
    bit [63:0] rc;
    bit [3:0]  pl;
    bit [3:0]  rl;
    bit [15:0] cap;
    int        plen;
    int        done;
    int        slen;
    int        r;
    for (int k = 0; k < 8; k++)
      pc[8*k +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h61 + 8'($urandom_range(2));
    rc = {$urandom, $urandom};
    r = $urandom_range(6);
    case (r)
      0: pl = 4'd0;
      1: pl = 4'd1;
      2: pl = 4'd8;
      3: pl = 4'($urandom_range(9, 15));
      default: pl = 4'($urandom_range(2, 7));
    endcase
    rl = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    r = $urandom_range(9);
    if (r == 0) cap = 16'd0;
    else if (r == 1) cap = 16'd1;
    else if (r < 5) cap = 16'($urandom_range(2, 30));
    else cap = 16'hffff;
    configure(pc, pl, rc, rl, cap);
    if (hold > 0) begin
      @(posedge clk);
      rx_hold_req = hold;
      @(negedge clk);
    end
    plen = (pl > WINDOW_MAX) ? WINDOW_MAX : pl;
    done = 0;
    while (done < n_items) begin
      slen = $urandom_range(14);
      for (int i = 0; i < slen; i++) begin
        if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        r = $urandom_range(9);
        if (r < 3 && plen > 0) begin
          for (int k = 0; k < plen; k++) send_beat(pc[8*k +: 8], 1'b1, 1'b0);
          done += plen;
        end else begin
          send_beat((r < 8) ? 8'h61 + 8'($urandom_range(2)) : 8'($urandom), 1'b1, 1'b0);
          done++;
        end
      end
      // close with a char or with an empty end marker
      if ($urandom_range(3) == 0) send_beat(8'($urandom), 1'b0, 1'b1);
      else send_beat(8'h61 + 8'($urandom_range(2)), 1'b1, 1'b1);
      done++;
    end
    settle();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_char = '0;
    in_has_char = 1'b0;
    in_last = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pattern "ab" -> "XYZ": overlap miss, extreme chars, ignored beat, empty string
    configure(64'h6261, 4'd2, 64'h5a5958, 4'd3, 16'hffff);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    settle();

    // new pattern length only applies from the next string
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h71, 1'b1, 1'b0);
    settle();
    write_reg(REG_PATTERN_LEN, 64'd1);
    send_beat(8'h61, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b1);
    settle();

    // plain copy, then capacity lowered below what is already written
    write_reg(REG_PATTERN_LEN, 64'd0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    settle();
    write_reg(REG_OUT_CAPACITY, 64'd1);
    send_beat(8'h63, 1'b1, 1'b1);
    settle();

    // empty replacement still counts with no room left
    configure(64'h61, 4'd1, 64'h0, 4'd0, 16'd0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b1);
    settle();

    // oversized lengths saturate; replacement cut at capacity
    configure({8{8'h61}}, 4'd15, {$urandom, $urandom}, 4'd15, 16'd5);
    repeat (7) send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h61, 1'b1, 1'b1);
    settle();

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        tx_idle_pct = 60;
        rx_idle_pct = 23;
      end
      if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_phase(38, (p == 1) ? 300 : 0);
    end

    if (sb.failures == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
